// ----- rtl/tdmc_pkg.sv -----
// Shared types, codes and reset values for the thermal door motor controller.
package tdmc_pkg;

  // Input word kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Motor direction codes
  localparam logic [1:0] DIR_OPEN  = 2'd0;
  localparam logic [1:0] DIR_CLOSE = 2'd1;
  localparam logic [1:0] DIR_STOP  = 2'd2;

  // Message codes
  localparam logic [2:0] MSG_NONE    = 3'd0;
  localparam logic [2:0] MSG_OPENING = 3'd1;
  localparam logic [2:0] MSG_CLOSING = 3'd2;
  localparam logic [2:0] MSG_UNREC   = 3'd3;
  localparam logic [2:0] MSG_HOT     = 3'd4;
  localparam logic [2:0] MSG_COOLED  = 3'd5;
  localparam logic [2:0] MSG_TEMP    = 3'd6;

  // Command characters
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_OPEN    = 8'h31;
  localparam logic [7:0] CHAR_CLOSE   = 8'h32;

  // Register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_TEMP_OPEN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TEMP_CLOSE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LOCKOUT     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REPORT      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CLOSED_X    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CLOSED_Z    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OPEN_Z      = 3'd6;

  // Register reset values
  localparam logic signed [7:0]  RST_TEMP_OPEN  = 8'sd27;
  localparam logic signed [7:0]  RST_TEMP_CLOSE = 8'sd25;
  localparam logic [11:0]        RST_LOCKOUT    = 12'd2000;
  localparam logic [9:0]         RST_REPORT     = 10'd100;
  localparam logic signed [15:0] RST_CLOSED_X   = -16'sd2048;
  localparam logic signed [15:0] RST_CLOSED_Z   = 16'sd26;
  localparam logic signed [15:0] RST_OPEN_Z     = 16'sd512;

  typedef struct packed {
    logic               kind;
    logic [7:0]         char_code;
    logic               buffer_end;
    logic [7:0]         temp_raw;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_z;
  } tdmc_in_t;

  typedef struct packed {
    logic [1:0]        motor_dir;
    logic [2:0]        message;
    logic signed [7:0] temperature;
  } tdmc_out_t;

endpackage

// ----- rtl/thermal_door_motor_controller_unit.sv -----
// Top level of the thermal door motor controller.
//
// Input channel: in_valid_i / in_stall_o carry one word, either a command
// character (kind 0) or a control tick (kind 1). Output channel:
// out_valid_o / out_stall_i carry exactly one result word per input word,
// in order. A word is taken at a rising edge with valid high and stall low.
// Configuration: cfg_we_i writes cfg_data_i into the register picked by
// cfg_idx_i at the next edge; unknown indexes are dropped. Write only while
// no words are in flight.
// Each word lands in the input register when it is taken and moves on to the
// result register when the result side is free; out_valid_o then rises. Throughput:
// one word per cycle while out_stall_i is low; the controller state updates
// as a word moves from the input register to the result register.
// Reset: all controller state and the configuration registers go to their
// defaults, both channels empty, motor stopped.
// Stall: while out_stall_i holds a result, one more word may sit in the
// input register; after that in_stall_o rises until the result is taken.
module thermal_door_motor_controller_unit
  import tdmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tdmc_in_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tdmc_out_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic signed [7:0]  temp_open_q, temp_close_q;
  logic [11:0]        lock_ticks_q;
  logic [9:0]         rpt_period_q;
  logic signed [15:0] closed_x_q, closed_z_q, open_z_q;

  // Channel registers
  logic      in_valid_q, out_valid_q;
  tdmc_in_t  in_q;
  tdmc_out_t out_q, out_d;
  logic      out_free, advance;

  // Controller state
  logic              door_open_q, door_open_d;
  logic              lock_act_q, lock_act_d;
  logic [11:0]       lock_cnt_q, lock_cnt_d;
  logic [1:0]        dir_q, dir_d;
  logic              hot_q, hot_d;
  logic              cool_q, cool_d;
  logic signed [7:0] last_temp_q, last_temp_d;
  logic [9:0]        rpt_cnt_q, rpt_cnt_d;
  logic              line_end_q, line_end_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_open_q  <= RST_TEMP_OPEN;
      temp_close_q <= RST_TEMP_CLOSE;
      lock_ticks_q <= RST_LOCKOUT;
      rpt_period_q <= RST_REPORT;
      closed_x_q   <= RST_CLOSED_X;
      closed_z_q   <= RST_CLOSED_Z;
      open_z_q     <= RST_OPEN_Z;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMP_OPEN:  temp_open_q  <= signed'(cfg_data_i[7:0]);
        REG_TEMP_CLOSE: temp_close_q <= signed'(cfg_data_i[7:0]);
        REG_LOCKOUT:    lock_ticks_q <= cfg_data_i[11:0];
        REG_REPORT:     rpt_period_q <= cfg_data_i[9:0];
        REG_CLOSED_X:   closed_x_q   <= signed'(cfg_data_i);
        REG_CLOSED_Z:   closed_z_q   <= signed'(cfg_data_i);
        REG_OPEN_Z:     open_z_q     <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Next state and result for the word in the input register
  always_comb begin
    logic signed [7:0] temp;
    logic [2:0]        msg;
    door_open_d = door_open_q;
    lock_act_d  = lock_act_q;
    lock_cnt_d  = lock_cnt_q;
    dir_d       = dir_q;
    hot_d       = hot_q;
    cool_d      = cool_q;
    last_temp_d = last_temp_q;
    rpt_cnt_d   = rpt_cnt_q;
    line_end_d  = line_end_q;
    temp        = 8'sd0;
    msg         = MSG_NONE;

    if (in_q.kind == KIND_CHAR) begin
      if (!line_end_q) begin
        if (in_q.char_code == CHAR_NEWLINE) begin
          line_end_d = 1'b1;
        end else if (in_q.char_code == CHAR_OPEN || in_q.char_code == CHAR_CLOSE) begin
          door_open_d = (in_q.char_code == CHAR_OPEN);
          dir_d       = (in_q.char_code == CHAR_OPEN) ? DIR_OPEN : DIR_CLOSE;
          msg         = (in_q.char_code == CHAR_OPEN) ? MSG_OPENING : MSG_CLOSING;
          lock_act_d  = 1'b1;
          lock_cnt_d  = '0;
        end else begin
          msg = MSG_UNREC;
        end
      end
      if (in_q.buffer_end) begin
        line_end_d = 1'b0;
      end
    end else begin
      temp = signed'(in_q.temp_raw);

      // Hysteresis control, skipped during lockout
      if (!lock_act_q) begin
        if (temp > temp_open_q && !door_open_q) begin
          door_open_d = 1'b1;
          hot_d       = 1'b1;
          dir_d       = DIR_OPEN;
        end else if (temp < temp_close_q && door_open_q) begin
          door_open_d = 1'b0;
          cool_d      = 1'b1;
          dir_d       = DIR_CLOSE;
        end
      end

      // End stops
      if (in_q.accel_z < closed_z_q && in_q.accel_x < closed_x_q && dir_d == DIR_CLOSE) begin
        dir_d = DIR_STOP;
      end else if (in_q.accel_z > open_z_q && dir_d == DIR_OPEN) begin
        dir_d = DIR_STOP;
      end

      if (lock_act_q) begin
        if (lock_cnt_q < lock_ticks_q) begin
          lock_cnt_d = lock_cnt_q + 12'd1;
        end else begin
          lock_cnt_d = '0;
          lock_act_d = 1'b0;
        end
      end

      // Status report; the count restarts from zero before the increment
      rpt_cnt_d = rpt_cnt_q + 10'd1;
      if (rpt_cnt_q >= rpt_period_q) begin
        rpt_cnt_d = 10'd1;
        if (hot_d) begin
          hot_d = 1'b0;
          msg   = MSG_HOT;
        end else if (cool_d) begin
          cool_d = 1'b0;
          msg    = MSG_COOLED;
        end else if (temp != last_temp_q) begin
          last_temp_d = temp;
          msg         = MSG_TEMP;
        end
      end
    end

    out_d.motor_dir   = dir_d;
    out_d.message     = msg;
    out_d.temperature = temp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      door_open_q <= 1'b0;
      lock_act_q  <= 1'b0;
      lock_cnt_q  <= '0;
      dir_q       <= DIR_STOP;
      hot_q       <= 1'b0;
      cool_q      <= 1'b0;
      last_temp_q <= '0;
      rpt_cnt_q   <= '0;
      line_end_q  <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        door_open_q <= door_open_d;
        lock_act_q  <= lock_act_d;
        lock_cnt_q  <= lock_cnt_d;
        dir_q       <= dir_d;
        hot_q       <= hot_d;
        cool_q      <= cool_d;
        last_temp_q <= last_temp_d;
        rpt_cnt_q   <= rpt_cnt_d;
        line_end_q  <= line_end_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- rtl/tdmc_checker.sv -----
// Port-level checker for the thermal door motor controller, with its bind.
module tdmc_checker
  import tdmc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input tdmc_out_t out_word_o
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // Command messages carry no temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.message == MSG_OPENING ||
      out_word_o.message == MSG_CLOSING || out_word_o.message == MSG_UNREC)
    |-> out_word_o.temperature == 8'sd0)
    else $error("command result with nonzero temperature");

  // An open or close command drives the motor that way at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.message == MSG_OPENING |-> out_word_o.motor_dir == DIR_OPEN)
    else $error("open command without open direction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.message == MSG_CLOSING |-> out_word_o.motor_dir == DIR_CLOSE)
    else $error("close command without close direction");

  // Input stall only rises while the result side is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with result side free");

endmodule

bind thermal_door_motor_controller_unit tdmc_checker u_tdmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the thermal door motor controller, with a predictor-based scoreboard.
module tb_top;
  import tdmc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  // Tracks the controller state and holds the results still owed by the block.
  class door_scoreboard;
    logic signed [7:0]  open_above, close_below;
    logic [11:0]        lock_len;
    logic [9:0]         period;
    logic signed [15:0] x_closed, z_closed, z_open;
    logic               door_open, locked, hot_due, cool_due, skip_line;
    logic [11:0]        lock_cnt;
    logic [1:0]         dir;
    logic [9:0]         rep_cnt;
    logic signed [7:0]  last_temp;
    tdmc_out_t          due_q[$];
    int                 errors;

    function new();
      open_above  = RST_TEMP_OPEN;
      close_below = RST_TEMP_CLOSE;
      lock_len    = RST_LOCKOUT;
      period      = RST_REPORT;
      x_closed    = RST_CLOSED_X;
      z_closed    = RST_CLOSED_Z;
      z_open      = RST_OPEN_Z;
      door_open   = 1'b0;
      locked      = 1'b0;
      hot_due     = 1'b0;
      cool_due    = 1'b0;
      skip_line   = 1'b0;
      lock_cnt    = '0;
      dir         = DIR_STOP;
      rep_cnt     = '0;
      last_temp   = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_TEMP_OPEN:  open_above  = data[7:0];
        REG_TEMP_CLOSE: close_below = data[7:0];
        REG_LOCKOUT:    lock_len    = data[11:0];
        REG_REPORT:     period      = data[9:0];
        REG_CLOSED_X:   x_closed    = data;
        REG_CLOSED_Z:   z_closed    = data;
        REG_OPEN_Z:     z_open      = data;
        default: ;
      endcase
    endfunction

    // Advance the state by one accepted word and queue the result it owes.
    function void note_word(tdmc_in_t w);
      tdmc_out_t          r;
      logic signed [7:0]  t;
      logic signed [15:0] ax, az;
      r.message = MSG_NONE;
      t = '0;
      if (w.kind == KIND_CHAR) begin
        if (!skip_line) begin
          if (w.char_code == CHAR_NEWLINE) begin
            skip_line = 1'b1;
          end else if (w.char_code == CHAR_OPEN || w.char_code == CHAR_CLOSE) begin
            dir       = (w.char_code == CHAR_OPEN) ? DIR_OPEN : DIR_CLOSE;
            door_open = (w.char_code == CHAR_OPEN);
            locked    = 1'b1;
            lock_cnt  = '0;
            r.message = (w.char_code == CHAR_OPEN) ? MSG_OPENING : MSG_CLOSING;
          end else begin
            r.message = MSG_UNREC;
          end
        end
        if (w.buffer_end) skip_line = 1'b0;
      end else begin
        t  = w.temp_raw;
        ax = w.accel_x;
        az = w.accel_z;
        if (!locked) begin
          if (t > open_above && !door_open) begin
            door_open = 1'b1;
            hot_due   = 1'b1;
            dir       = DIR_OPEN;
          end else if (t < close_below && door_open) begin
            door_open = 1'b0;
            cool_due  = 1'b1;
            dir       = DIR_CLOSE;
          end
        end
        if (az < z_closed && ax < x_closed && dir == DIR_CLOSE) begin
          dir = DIR_STOP;
        end else if (az > z_open && dir == DIR_OPEN) begin
          dir = DIR_STOP;
        end
        if (locked) begin
          if (lock_cnt < lock_len) begin
            lock_cnt = lock_cnt + 12'd1;
          end else begin
            lock_cnt = '0;
            locked   = 1'b0;
          end
        end
        if (rep_cnt >= period) begin
          rep_cnt = '0;
          if (hot_due) begin
            hot_due   = 1'b0;
            r.message = MSG_HOT;
          end else if (cool_due) begin
            cool_due  = 1'b0;
            r.message = MSG_COOLED;
          end else if (t != last_temp) begin
            last_temp = t;
            r.message = MSG_TEMP;
          end
        end
        rep_cnt = rep_cnt + 10'd1;
      end
      r.motor_dir   = dir;
      r.temperature = t;
      due_q.push_back(r);
    endfunction

    function void check_word(tdmc_out_t got);
      tdmc_out_t exp_w;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: dir %0d msg %0d temp %0d",
                   got.motor_dir, got.message, got.temperature);
        return;
      end
      exp_w = due_q.pop_front();
      if (got.motor_dir != exp_w.motor_dir || got.message != exp_w.message ||
          got.temperature != exp_w.temperature) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: dir exp %0d got %0d, msg exp %0d got %0d, temp exp %0d got %0d",
                   exp_w.motor_dir, got.motor_dir, exp_w.message, got.message,
                   exp_w.temperature, got.temperature);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  tdmc_in_t            in_word;
  logic                out_valid;
  logic                out_stall;
  tdmc_out_t           out_word;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  door_scoreboard sb;
  bit             quiet;
  int             stall_left;
  int unsigned    cycles;

  thermal_door_motor_controller_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Take result words and draw the stall for the next one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_word(out_word);
      stall_left = quiet ? 0 : $urandom_range(0, 13);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [7:0] near8(logic signed [7:0] c);
    int v;
    v = c;
    v = v + int'($urandom_range(0, 8)) - 4;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v[7:0];
  endfunction

  function automatic logic [15:0] near16(logic signed [15:0] c);
    int v;
    v = c;
    v = v + int'($urandom_range(0, 8)) - 4;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic tdmc_in_t noise_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(tdmc_in_t)-1:0];
  endfunction

  function automatic tdmc_in_t mk_char(logic [7:0] c, logic be);
    tdmc_in_t w;
    w            = noise_word();
    w.kind       = KIND_CHAR;
    w.char_code  = c;
    w.buffer_end = be;
    return w;
  endfunction

  function automatic tdmc_in_t mk_tick(logic [7:0] t, logic [15:0] x, logic [15:0] z);
    tdmc_in_t w;
    w          = noise_word();
    w.kind     = KIND_TICK;
    w.temp_raw = t;
    w.accel_x  = x;
    w.accel_z  = z;
    return w;
  endfunction

  // Ticks cluster around the thresholds and end-stop limits.
  function automatic tdmc_in_t rand_tick();
    tdmc_in_t w;
    int       sel;
    w      = noise_word();
    w.kind = KIND_TICK;
    sel    = $urandom_range(0, 9);
    if (sel < 4) w.temp_raw = near8(sb.open_above);
    else if (sel < 8) w.temp_raw = near8(sb.close_below);
    if ($urandom_range(0, 9) < 6) begin
      w.accel_x = near16(sb.x_closed);
      w.accel_z = $urandom_range(0, 1) ? near16(sb.z_closed) : near16(sb.z_open);
    end
    return w;
  endfunction

  function automatic tdmc_in_t rand_char();
    tdmc_in_t w;
    int       sel;
    w            = noise_word();
    w.kind       = KIND_CHAR;
    w.buffer_end = ($urandom_range(0, 3) == 0);
    sel          = $urandom_range(0, 9);
    if (sel < 3) w.char_code = CHAR_OPEN;
    else if (sel < 6) w.char_code = CHAR_CLOSE;
    else if (sel < 8) w.char_code = CHAR_NEWLINE;
    return w;
  endfunction

  // Enter at a falling edge; leave at the falling edge after the word is taken.
  task automatic send_word(input tdmc_in_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(posedge clk_i);
    end while (in_stall);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CfgDataW-1:0];
    sb.set_reg(idx, value[CfgDataW-1:0]);
    @(negedge clk_i);
  endtask

  task automatic wait_settled();
    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apply_config(input int open_t, input int close_t, input int lock_n,
                              input int rep_n, input int x_lim, input int z_lim,
                              input int zo_lim);
    wait_settled();
    write_reg(REG_TEMP_OPEN, open_t);
    write_reg(REG_TEMP_CLOSE, close_t);
    write_reg(REG_LOCKOUT, lock_n);
    write_reg(REG_REPORT, rep_n);
    write_reg(REG_CLOSED_X, x_lim);
    write_reg(REG_CLOSED_Z, z_lim);
    write_reg(REG_OPEN_Z, zo_lim);
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_config();
    int open_t;
    open_t = int'($urandom_range(0, 80)) - 30;
    apply_config(open_t, open_t - int'($urandom_range(0, 8)) + 1,
                 $urandom_range(0, 12), $urandom_range(1, 8),
                 int'($urandom_range(0, 4096)) - 2048, int'($urandom_range(0, 1024)) - 512,
                 int'($urandom_range(0, 1024)) - 256);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_word(($urandom_range(0, 3) == 0) ? rand_char() : rand_tick());
    end
    quiet = 1'b0;
  endtask

  initial begin
    sb         = new();
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_data   = '0;
    quiet      = 1'b0;
    stall_left = 0;
    cycles     = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults: hysteresis, end stops, and line skipping after a newline.
    send_word(mk_tick(8'd30, 16'd0, 16'd0));
    send_word(mk_tick(8'd30, 16'd0, 16'd600));
    send_word(mk_tick(8'd20, -16'sd3000, 16'd0));
    send_word(mk_char("A", 1'b0));
    send_word(mk_char(CHAR_NEWLINE, 1'b0));
    send_word(mk_char(CHAR_OPEN, 1'b0));
    send_word(mk_char(CHAR_CLOSE, 1'b1));
    send_word(mk_char(8'h00, 1'b1));
    send_word(mk_char(8'hFF, 1'b0));

    // Short lockout and report every tick: pending reports, lockout expiry.
    apply_config(27, 25, 2, 1, -2048, 26, 512);
    send_word(mk_char(CHAR_OPEN, 1'b1));
    send_word(mk_tick(8'h80, 16'h7FFF, 16'h8000));
    send_word(mk_tick(8'h7F, 16'h0000, 16'h7FFF));
    send_word(mk_tick(8'h7F, 16'h0000, 16'h0000));
    send_word(mk_tick(8'd20, 16'h8000, 16'h8000));
    send_word(mk_char(CHAR_CLOSE, 1'b1));
    send_word(mk_tick(8'd40, 16'h8000, 16'h8000));
    send_word(mk_tick(8'd26, 16'd0, 16'd0));
    send_word(mk_tick(8'd26, 16'd0, 16'd0));
    send_word(mk_tick(8'd28, 16'd0, 16'd0));
    send_word(mk_tick(8'd28, 16'd0, 16'd513));
    send_word(mk_char(CHAR_OPEN, 1'b1));
    send_word(mk_char(CHAR_NEWLINE, 1'b1));
    send_word(mk_char(CHAR_CLOSE, 1'b1));

    apply_config(27, 25, 4, 2, -2048, 26, 512);
    run_random(350);
    apply_config(-128, 127, 0, 1, -32768, 32767, 32767);
    run_random(300);
    apply_config(127, -128, 4095, 1023, 32767, -32768, -32768);
    run_random(200);
    random_config();
    run_random(300);
    random_config();
    run_random(300);
    random_config();
    run_random(300);

    wait_settled();
    repeat (8) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
